// ===== hw/rtl/lssa_pkg.sv =====
// ----------------------------------------------------------------------------
// Line speed set point adjust package
// Shared constants, codes and structs of the set point adjust block.
// ----------------------------------------------------------------------------
package lssa_pkg;

    localparam int NUM_SECTIONS_DEF = 4;
    localparam int HOLD_STEPS_DEF   = 6;

    localparam int TEMP_W  = 18;
    localparam int THICK_W = 13;
    localparam int SPEED_W = 23;
    localparam int DELTA_W = 18;
    localparam int MULT_W  = 23;
    localparam int HOLD_W  = 3;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 23'd8000000;
    localparam logic [THICK_W-1:0] THICK_MIN = 13'd100;
    localparam logic [THICK_W-1:0] THICK_MAX = 13'd6000;

    // Gain numerators in um, 0.8 mm and 1 mm.
    localparam logic [9:0] GAIN_NUM_DEC = 10'd800;
    localparam logic [9:0] GAIN_NUM_INC = 10'd1000;

    // Speed step divisor 60 * 2^16 and its half for rounding.
    localparam logic [39:0] DIV_SPD  = 40'd3932160;
    localparam logic [39:0] DIV_HALF = 40'd1966080;
    localparam logic [13:0] DIFF_SCALE = 14'd10000;

    typedef enum logic [2:0] {
        CFG_TARGET_TEMP = 3'd0,
        CFG_UPPER_TEMP  = 3'd1,
        CFG_LOWER_TEMP  = 3'd2,
        CFG_THICKNESS   = 3'd3,
        CFG_FINAL_SPEED = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        OP_DECREASE = 2'd0,
        OP_INCREASE = 2'd1,
        OP_LOAD     = 2'd2,
        OP_UNUSED   = 2'd3
    } t_operation;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_LIN  = 2'd1,
        STEP_CAP  = 2'd2,
        STEP_DIFF = 2'd3
    } t_step_kind;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DECODE = 2'd1,
        ST_WAIT   = 2'd2,
        ST_WRITE  = 2'd3
    } t_top_state;

    typedef enum logic [2:0] {
        U_IDLE  = 3'd0,
        U_GAIN  = 3'd1,
        U_PREP  = 3'd2,
        U_MUL   = 3'd3,
        U_CLAMP = 3'd4,
        U_DIV   = 3'd5,
        U_DONE  = 3'd6
    } t_unit_state;

    typedef struct packed {
        logic                start;
        t_step_kind          kind;
        logic                gain_inc;
        logic [MULT_W-1:0]   mult;
        logic [SPEED_W-1:0]  lo;
        logic [SPEED_W-1:0]  hi;
    } t_step_req;

    typedef struct packed {
        logic                done;
        logic [DELTA_W-1:0]  delta;
    } t_step_rsp;

endpackage

// ===== hw/rtl/lssa_step_unit.sv =====
// ----------------------------------------------------------------------------
// Speed step unit
// Serial gain division, shift-add product, clamp and rounding division.
// ----------------------------------------------------------------------------
module lssa_step_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lssa_pkg::t_step_req             i_req,
    input  logic [lssa_pkg::THICK_W-1:0]    i_thickness,
    output lssa_pkg::t_step_rsp             o_rsp
);

    lssa_pkg::t_unit_state r_state, n_state;
    logic [5:0]  r_cnt;
    lssa_pkg::t_step_kind r_kind;
    logic [lssa_pkg::MULT_W-1:0]  r_mult;
    logic [lssa_pkg::SPEED_W-1:0] r_lo, r_hi;
    logic [12:0] r_t;
    logic [13:0] r_grem;
    logic [19:0] r_gnum;
    logic [19:0] r_gq;
    logic [31:0] r_m;
    logic [51:0] r_acc, r_gsh;
    logic [39:0] r_drem, r_dsh;
    logic [lssa_pkg::DELTA_W-1:0] r_q;

    logic [12:0] w_t;
    logic [25:0] w_num;
    logic [13:0] w_grem_sh;
    logic        w_gbit;
    logic [51:0] w_p, w_lo_q, w_hi_q;
    logic        w_dbit;

    always_comb begin
        if (i_thickness < lssa_pkg::THICK_MIN) begin
            w_t = lssa_pkg::THICK_MIN;
        end else if (i_thickness > lssa_pkg::THICK_MAX) begin
            w_t = lssa_pkg::THICK_MAX;
        end else begin
            w_t = i_thickness;
        end
        // Rounded quotient: the half divisor is folded into the dividend.
        w_num = {(i_req.gain_inc ? lssa_pkg::GAIN_NUM_INC : lssa_pkg::GAIN_NUM_DEC), 16'b0}
              + 26'(w_t >> 1);
        w_grem_sh = {r_grem[12:0], r_gnum[19]};
        w_gbit    = (w_grem_sh >= 14'(r_t));
        w_lo_q = 52'({r_lo, 16'b0});
        w_hi_q = 52'({r_hi, 16'b0});
        w_p = r_acc;
        if (r_kind == lssa_pkg::STEP_CAP) begin
            if (w_p > w_hi_q) w_p = w_hi_q;
        end else if (r_kind == lssa_pkg::STEP_DIFF) begin
            if (w_p < w_lo_q) w_p = w_lo_q;
            if (w_p > w_hi_q) w_p = w_hi_q;
        end
        w_dbit = (r_drem >= r_dsh);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lssa_pkg::U_IDLE: begin
                if (i_req.start) begin
                    n_state = (i_req.kind == lssa_pkg::STEP_NONE) ? lssa_pkg::U_DONE
                                                                  : lssa_pkg::U_GAIN;
                end
            end
            lssa_pkg::U_GAIN:  if (r_cnt == 6'd0) n_state = lssa_pkg::U_PREP;
            lssa_pkg::U_PREP:  n_state = lssa_pkg::U_MUL;
            lssa_pkg::U_MUL:   if (r_cnt == 6'd0) n_state = lssa_pkg::U_CLAMP;
            lssa_pkg::U_CLAMP: n_state = lssa_pkg::U_DIV;
            lssa_pkg::U_DIV:   if (r_cnt == 6'd0) n_state = lssa_pkg::U_DONE;
            lssa_pkg::U_DONE:  n_state = lssa_pkg::U_IDLE;
            default:           n_state = lssa_pkg::U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lssa_pkg::U_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            lssa_pkg::U_IDLE: begin
                r_kind <= i_req.kind;
                r_mult <= i_req.mult;
                r_lo   <= i_req.lo;
                r_hi   <= i_req.hi;
                r_t    <= w_t;
                r_grem <= 14'(w_num[25:20]);
                r_gnum <= w_num[19:0];
                r_q    <= '0;
                r_cnt  <= 6'd19;
            end
            lssa_pkg::U_GAIN: begin
                r_cnt  <= r_cnt - 6'd1;
                r_grem <= w_gbit ? (w_grem_sh - 14'(r_t)) : w_grem_sh;
                r_gnum <= {r_gnum[18:0], 1'b0};
                r_gq   <= {r_gq[18:0], w_gbit};
            end
            lssa_pkg::U_PREP: begin
                r_m   <= (r_kind == lssa_pkg::STEP_DIFF) ? 32'(r_mult * lssa_pkg::DIFF_SCALE)
                                                         : 32'(r_mult);
                r_acc <= '0;
                r_gsh <= 52'(r_gq);
                r_cnt <= 6'd31;
            end
            lssa_pkg::U_MUL: begin
                r_cnt <= r_cnt - 6'd1;
                if (r_m[0]) r_acc <= r_acc + r_gsh;
                r_m   <= {1'b0, r_m[31:1]};
                r_gsh <= {r_gsh[50:0], 1'b0};
            end
            lssa_pkg::U_CLAMP: begin
                r_drem <= 40'(w_p) + lssa_pkg::DIV_HALF;
                r_dsh  <= lssa_pkg::DIV_SPD << (lssa_pkg::DELTA_W - 1);
                r_cnt  <= 6'(lssa_pkg::DELTA_W - 1);
            end
            lssa_pkg::U_DIV: begin
                r_cnt <= r_cnt - 6'd1;
                if (w_dbit) r_drem <= r_drem - r_dsh;
                r_dsh <= {1'b0, r_dsh[39:1]};
                r_q   <= {r_q[lssa_pkg::DELTA_W-2:0], w_dbit};
            end
            default: ;
        endcase
    end

    assign o_rsp.done  = (r_state == lssa_pkg::U_DONE);
    assign o_rsp.delta = r_q;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lssa_pkg::U_DONE) |=> (r_state == lssa_pkg::U_IDLE))
        else $error("step unit did not return to idle after done");

    a_gain_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lssa_pkg::U_GAIN) |-> (r_cnt <= 6'd19))
        else $error("gain division count out of range");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lssa_pkg::U_DIV) |-> (r_cnt <= 6'(lssa_pkg::DELTA_W - 1)))
        else $error("rounding division count out of range");

endmodule

// ===== hw/rtl/line_speed_setpoint_adjust.sv =====
// ----------------------------------------------------------------------------
// Line speed set point adjust
// Graded decrease, increase and load of per-section line speed set points.
// ----------------------------------------------------------------------------
// Sequence: a step that computes a speed delta passes decode, then the step
// unit's gain division, product, clamp, rounding division and done, then
// write; an item that starts no step (load, out-of-range section, increase
// hold or no rule applied) goes from decode straight to write.
// Throughput: one word at a time; the next word is taken only after the
// previous one has been written to the output register.
// Reset clears the set points, both hold counters and the output valid, and
// loads the configuration registers with their default values.
module line_speed_setpoint_adjust #(
    parameter int NUM_SECTIONS = lssa_pkg::NUM_SECTIONS_DEF,
    parameter int HOLD_STEPS   = lssa_pkg::HOLD_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input word, from bit 0: operation[1:0], section[3:2], strip_temp[21:4],
    // previous_strip_temp[39:22], anticipation_passed[40], load_speed[63:41].
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    // Output word, from bit 0: speed_setpoint[22:0], speed_changed[23].
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    // Configuration write port.
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [22:0] i_cfg_data
);

    localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
    localparam logic [lssa_pkg::HOLD_W-1:0] HOLD_INIT = lssa_pkg::HOLD_W'(HOLD_STEPS);

    // Configuration registers.
    logic [17:0] r_target_temp, r_upper_temp, r_lower_temp;
    logic [12:0] r_thickness;
    logic [22:0] r_final_speed;

    // Captured input word.
    logic [1:0]  r_operation, r_section;
    logic [17:0] r_strip_temp, r_prev_temp;
    logic        r_anticipation;
    logic [22:0] r_load_speed;

    // Block state.
    logic [22:0] r_speed [NUM_SECTIONS];
    logic [lssa_pkg::HOLD_W-1:0] r_dec_hold, r_inc_hold;

    lssa_pkg::t_top_state r_state, n_state;
    logic        r_apply;
    logic [lssa_pkg::DELTA_W-1:0] r_delta;
    logic        r_out_valid;
    logic [22:0] r_out_speed;
    logic        r_out_changed;

    lssa_pkg::t_step_req w_req;
    lssa_pkg::t_step_rsp w_rsp;

    // Decode results.
    logic        w_sec_ok;
    logic [SEC_W-1:0] w_ix;
    logic [22:0] w_old, w_fin, w_new;
    logic        w_apply;
    logic [lssa_pkg::HOLD_W-1:0] w_dec_hold_n, w_inc_hold_n;
    logic        w_slot;

    // Signed copies of the temperatures so that offsets below zero compare
    // the same way as in the control rules.
    logic signed [20:0] s_tgt, s_upp, s_low, s_tmp, s_prev;
    logic signed [20:0] s_dec_lim, s_inc_lim, s_dt;
    logic        w_go;
    logic [lssa_pkg::HOLD_W-1:0] w_hold1;

    assign s_tgt  = $signed({3'b000, r_target_temp});
    assign s_upp  = $signed({3'b000, r_upper_temp});
    assign s_low  = $signed({3'b000, r_lower_temp});
    assign s_tmp  = $signed({3'b000, r_strip_temp});
    assign s_prev = $signed({3'b000, r_prev_temp});

    assign w_sec_ok = (int'(r_section) < NUM_SECTIONS);
    assign w_ix     = SEC_W'(r_section);
    assign w_old    = r_speed[w_ix];
    assign w_fin    = (r_final_speed > lssa_pkg::SPEED_MAX) ? lssa_pkg::SPEED_MAX
                                                            : r_final_speed;
    assign w_slot   = !r_out_valid || m_axis_tready;

    // Step selection for the decrease and increase rules.
    always_comb begin
        w_req.start    = 1'b0;
        w_req.kind     = lssa_pkg::STEP_NONE;
        w_req.gain_inc = (r_operation == lssa_pkg::OP_INCREASE);
        w_req.mult     = '0;
        w_req.lo       = '0;
        w_req.hi       = '0;
        w_apply        = 1'b0;
        w_dec_hold_n   = r_dec_hold;
        w_inc_hold_n   = r_inc_hold;
        s_dt           = '0;
        w_go           = 1'b0;
        w_hold1        = '0;

        if (r_anticipation) begin
            s_dec_lim = (s_upp + 21'sd5000 > s_tgt) ? s_upp + 21'sd5000 : s_tgt;
        end else begin
            s_dec_lim = (s_upp > s_tgt) ? s_upp : s_tgt;
            if (s_tgt + 21'sd400 < s_dec_lim) s_dec_lim = s_tgt + 21'sd400;
        end
        s_inc_lim = (s_low + 21'sd1000 < s_tgt - 21'sd150) ? s_low + 21'sd1000
                                                           : s_tgt - 21'sd150;
        if (s_tgt - 21'sd100 > s_inc_lim) s_inc_lim = s_tgt - 21'sd100;

        if (r_operation == lssa_pkg::OP_DECREASE && s_tmp <= s_dec_lim) begin
            w_apply = 1'b1;
            if (!r_anticipation) begin
                w_hold1      = (r_dec_hold != '0) ? r_dec_hold - 1'b1 : r_dec_hold;
                w_dec_hold_n = HOLD_INIT;
                w_req.kind   = lssa_pkg::STEP_LIN;
                w_req.mult   = 23'd150000;
                if (w_hold1 == '0) begin
                    if (s_tmp + 21'sd30 < s_prev) begin
                        s_dt       = s_tgt + 21'sd400 - s_tmp;
                        w_req.kind = lssa_pkg::STEP_DIFF;
                        w_req.lo   = 23'd50000;
                        w_req.hi   = 23'd4000000;
                    end else if (s_tmp + 21'sd800 < s_tgt) begin
                        w_req.kind = lssa_pkg::STEP_CAP;
                        w_req.mult = 23'd350000;
                        w_req.hi   = 23'd350000;
                    end else if (s_tmp + 21'sd550 < s_tgt) begin
                        w_req.kind = lssa_pkg::STEP_CAP;
                        w_req.mult = 23'd250000;
                        w_req.hi   = 23'd250000;
                    end else if (s_tmp < s_upp) begin
                        w_req.kind = lssa_pkg::STEP_CAP;
                        w_req.mult = 23'd100000;
                        w_req.hi   = 23'd100000;
                    end
                end
            end else begin
                w_req.kind = lssa_pkg::STEP_LIN;
                w_req.mult = 23'd200000;
                if (s_tmp + 21'sd30 < s_prev) begin
                    s_dt       = s_tgt + 21'sd1400 - s_tmp;
                    w_req.kind = lssa_pkg::STEP_DIFF;
                    w_req.lo   = 23'd650000;
                    w_req.hi   = 23'd4000000;
                end else if (s_tmp + 21'sd700 < s_tgt) begin
                    w_req.kind = lssa_pkg::STEP_CAP;
                    w_req.mult = 23'd1000000;
                    w_req.hi   = 23'd1000000;
                end else if (s_tmp + 21'sd350 < s_tgt) begin
                    w_req.kind = lssa_pkg::STEP_CAP;
                    w_req.mult = 23'd300000;
                    w_req.hi   = 23'd300000;
                end else if (s_tmp < s_upp) begin
                    w_req.kind = lssa_pkg::STEP_CAP;
                    w_req.mult = 23'd200000;
                    w_req.hi   = 23'd200000;
                end
            end
        end

        if (r_operation == lssa_pkg::OP_INCREASE) begin
            w_go = (s_tmp >= s_upp + 21'sd150)
                || (s_tmp >= s_inc_lim && s_tmp > s_prev - 21'sd1)
                || (s_tmp >= s_tgt - 21'sd700 && s_tmp > s_prev + 21'sd8);
            if (w_go) begin
                w_hold1      = (r_inc_hold != '0) ? r_inc_hold - 1'b1 : r_inc_hold;
                w_inc_hold_n = w_hold1;
                if (w_hold1 == '0) begin
                    w_apply      = 1'b1;
                    w_inc_hold_n = HOLD_INIT;
                    // A falling strip temperature well inside the band holds
                    // the speed, which still takes the final speed cap.
                    if (!(s_tmp < s_prev - 21'sd3 && s_tmp < s_upp - 21'sd100)) begin
                        w_req.kind = lssa_pkg::STEP_LIN;
                        w_req.mult = 23'd450000;
                        if (s_tmp > s_prev + 21'sd30) begin
                            s_dt       = s_tmp - s_inc_lim;
                            w_req.kind = lssa_pkg::STEP_DIFF;
                            w_req.lo   = 23'd50000;
                            w_req.hi   = 23'd4000000;
                        end else if (s_tmp >= s_tgt + 21'sd1400) begin
                            w_req.kind = lssa_pkg::STEP_CAP;
                            w_req.mult = 23'd6000000;
                            w_req.hi   = 23'd1400000;
                        end else if (s_tmp >= s_tgt + 21'sd800) begin
                            w_req.kind = lssa_pkg::STEP_CAP;
                            w_req.mult = 23'd3000000;
                            w_req.hi   = 23'd1200000;
                        end else if (s_tmp >= s_tgt + 21'sd450) begin
                            w_req.kind = lssa_pkg::STEP_CAP;
                            w_req.mult = 23'd1500000;
                            w_req.hi   = 23'd700000;
                        end else if (s_tmp >= s_tgt - 21'sd100 && s_tmp > s_prev + 21'sd7) begin
                            w_req.kind = lssa_pkg::STEP_CAP;
                            w_req.mult = 23'd2000000;
                            w_req.hi   = 23'd800000;
                        end else if (s_tmp >= s_tgt + 21'sd100) begin
                            w_req.kind = lssa_pkg::STEP_CAP;
                            w_req.mult = 23'd750000;
                            w_req.hi   = 23'd300000;
                        end
                    end
                end
            end
        end

        // A negative temperature difference clamps to the low bound.
        if (w_req.kind == lssa_pkg::STEP_DIFF) begin
            w_req.mult = (s_dt < 21'sd0) ? '0 : 23'(s_dt);
        end
        w_req.start = (r_state == lssa_pkg::ST_DECODE) && w_sec_ok && w_apply;
    end

    lssa_step_unit u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_thickness (r_thickness),
        .o_rsp       (w_rsp)
    );

    // New set point of the handled section.
    always_comb begin
        w_new = w_old;
        unique case (r_operation)
            lssa_pkg::OP_DECREASE: begin
                if (r_apply) begin
                    if ({1'b0, w_old} >= {1'b0, w_fin} + 24'(r_delta)) begin
                        w_new = w_old - 23'(r_delta);
                    end else begin
                        w_new = w_fin;
                    end
                end
            end
            lssa_pkg::OP_INCREASE: begin
                if (r_apply) begin
                    if ({1'b0, w_old} + 24'(r_delta) > {1'b0, w_fin}) begin
                        w_new = w_fin;
                    end else begin
                        w_new = w_old + 23'(r_delta);
                    end
                end
            end
            lssa_pkg::OP_LOAD: begin
                w_new = (r_load_speed > lssa_pkg::SPEED_MAX) ? lssa_pkg::SPEED_MAX
                                                             : r_load_speed;
            end
            default: w_new = w_old;
        endcase
    end

    // Control sequence: capture, decode, wait for the step unit, write back.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lssa_pkg::ST_IDLE: begin
                if (s_axis_tvalid) n_state = lssa_pkg::ST_DECODE;
            end
            lssa_pkg::ST_DECODE: begin
                n_state = w_req.start ? lssa_pkg::ST_WAIT : lssa_pkg::ST_WRITE;
            end
            lssa_pkg::ST_WAIT: begin
                if (w_rsp.done) n_state = lssa_pkg::ST_WRITE;
            end
            lssa_pkg::ST_WRITE: begin
                if (w_slot) n_state = lssa_pkg::ST_IDLE;
            end
            default: n_state = lssa_pkg::ST_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == lssa_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lssa_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_dec_hold  <= '0;
            r_inc_hold  <= '0;
            r_apply     <= 1'b0;
            for (int i = 0; i < NUM_SECTIONS; i++) r_speed[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == lssa_pkg::ST_DECODE) begin
                r_apply <= w_apply;
                if (w_sec_ok) begin
                    r_dec_hold <= w_dec_hold_n;
                    r_inc_hold <= w_inc_hold_n;
                end
            end
            if (r_state == lssa_pkg::ST_WRITE && w_slot) begin
                r_out_valid <= 1'b1;
                if (w_sec_ok) r_speed[w_ix] <= w_new;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lssa_pkg::ST_IDLE) begin
            r_operation    <= s_axis_tdata[1:0];
            r_section      <= s_axis_tdata[3:2];
            r_strip_temp   <= s_axis_tdata[21:4];
            r_prev_temp    <= s_axis_tdata[39:22];
            r_anticipation <= s_axis_tdata[40];
            r_load_speed   <= s_axis_tdata[63:41];
        end
        if (r_state == lssa_pkg::ST_DECODE) r_delta <= '0;
        if (w_rsp.done) r_delta <= w_rsp.delta;
        if (r_state == lssa_pkg::ST_WRITE && w_slot) begin
            r_out_speed   <= w_sec_ok ? w_new : '0;
            r_out_changed <= w_sec_ok && (w_new != w_old);
        end
    end

    // Configuration registers; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_temp <= 18'd80000;
            r_upper_temp  <= 18'd81000;
            r_lower_temp  <= 18'd79000;
            r_thickness   <= 13'd1000;
            r_final_speed <= 23'd1000000;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                lssa_pkg::CFG_TARGET_TEMP: r_target_temp <= i_cfg_data[17:0];
                lssa_pkg::CFG_UPPER_TEMP:  r_upper_temp  <= i_cfg_data[17:0];
                lssa_pkg::CFG_LOWER_TEMP:  r_lower_temp  <= i_cfg_data[17:0];
                lssa_pkg::CFG_THICKNESS:   r_thickness   <= i_cfg_data[12:0];
                lssa_pkg::CFG_FINAL_SPEED: r_final_speed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_changed, r_out_speed};

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == lssa_pkg::ST_WAIT))
        else $error("step result arrived outside the wait state");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[22:0] <= lssa_pkg::SPEED_MAX))
        else $error("set point above the speed limit");

    a_hold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dec_hold <= HOLD_INIT) && (r_inc_hold <= HOLD_INIT))
        else $error("hold counter above its preset");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word accepted while one is in work");

endmodule
